FILE: rtl/core/tcf_pkg.sv
`default_nettype none

package tcf_pkg;

  // Default widths of the colour channels and of the millisecond counter.
  localparam int unsigned ChannelBitsDef = 8;
  localparam int unsigned TimeBitsDef    = 16;

  // Fixed widths of the channel payload fields.
  localparam int unsigned PortChBits   = 8;
  localparam int unsigned PortTimeBits = 16;

  // Channel layout: red, green, blue, alpha.
  localparam int unsigned NumCh    = 4;
  localparam int unsigned NumRgb   = 3;
  localparam int unsigned AlphaIdx = 3;
  localparam int unsigned LaneW    = $clog2(NumCh);

  // Operation codes of an input item.
  localparam logic OpTick  = 1'b0;
  localparam logic OpStart = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             lane_mul;
    logic [LaneW-1:0] lane_sel;
    logic             div_step;
    logic             commit;
  } tcf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic active;
    logic expired;
  } tcf_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/tcf_if.sv
`default_nettype none

// Input channel: one fade command or time tick per transfer.
interface tcf_in_if import tcf_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [PortChBits-1:0]   target_red;
  logic [PortChBits-1:0]   target_green;
  logic [PortChBits-1:0]   target_blue;
  logic [PortChBits-1:0]   target_alpha;
  logic [PortTimeBits-1:0] duration_ms;
  logic [PortTimeBits-1:0] elapsed_ms;

  modport source (
    output valid, op, target_red, target_green, target_blue, target_alpha,
           duration_ms, elapsed_ms,
    input  ready
  );
  modport sink (
    input  valid, op, target_red, target_green, target_blue, target_alpha,
           duration_ms, elapsed_ms,
    output ready
  );
endinterface

// Output channel: the fade state after each input item.
interface tcf_out_if import tcf_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [PortChBits-1:0] color_red;
  logic [PortChBits-1:0] color_green;
  logic [PortChBits-1:0] color_blue;
  logic [PortChBits-1:0] color_alpha;
  logic [PortChBits-1:0] overlay_red;
  logic [PortChBits-1:0] overlay_green;
  logic [PortChBits-1:0] overlay_blue;
  logic [PortChBits-1:0] overlay_alpha;
  logic [PortChBits-1:0] modulation;
  logic                  fading;
  logic                  overlay_mode;

  modport source (
    output valid, color_red, color_green, color_blue, color_alpha, overlay_red,
           overlay_green, overlay_blue, overlay_alpha, modulation, fading,
           overlay_mode,
    input  ready
  );
  modport sink (
    input  valid, color_red, color_green, color_blue, color_alpha, overlay_red,
           overlay_green, overlay_blue, overlay_alpha, modulation, fading,
           overlay_mode,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/tcf_ctrl.sv
`default_nettype none

module tcf_ctrl import tcf_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = ChannelBitsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire tcf_sts_t sts_i,
  output tcf_cmd_t      cmd_o
);

  localparam int unsigned CntMax = (CHANNEL_BITS > NumCh) ? CHANNEL_BITS : NumCh;
  localparam int unsigned CntW   = $clog2(CntMax);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StFin   = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            in_xfer;
  logic            out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Sequencing: load, check, one multiply per lane, divide all lanes, commit.
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    out_valid_d    = out_valid_q;
    cmd_o          = '0;
    cmd_o.lane_sel = cnt_q[LaneW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        cnt_d = '0;
        if (!sts_i.active || sts_i.expired) begin
          state_d = StFin;
        end else begin
          state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.lane_mul = 1'b1;
        if (cnt_q == CntW'(NumCh - 1)) begin
          cnt_d   = '0;
          state_d = StDiv;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CntW'(CHANNEL_BITS - 1)) begin
          cnt_d   = '0;
          state_d = StFin;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StFin: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tcf_dp.sv
`default_nettype none

module tcf_dp import tcf_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = ChannelBitsDef,
  parameter int unsigned TIME_BITS    = TimeBitsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire tcf_cmd_t                cmd_i,
  output tcf_sts_t                     sts_o,
  input  wire logic                    op_i,
  input  wire logic [PortChBits-1:0]   target_red_i,
  input  wire logic [PortChBits-1:0]   target_green_i,
  input  wire logic [PortChBits-1:0]   target_blue_i,
  input  wire logic [PortChBits-1:0]   target_alpha_i,
  input  wire logic [PortTimeBits-1:0] duration_ms_i,
  input  wire logic [PortTimeBits-1:0] elapsed_ms_i,
  output logic [PortChBits-1:0]        color_red_o,
  output logic [PortChBits-1:0]        color_green_o,
  output logic [PortChBits-1:0]        color_blue_o,
  output logic [PortChBits-1:0]        color_alpha_o,
  output logic [PortChBits-1:0]        overlay_red_o,
  output logic [PortChBits-1:0]        overlay_green_o,
  output logic [PortChBits-1:0]        overlay_blue_o,
  output logic [PortChBits-1:0]        overlay_alpha_o,
  output logic [PortChBits-1:0]        modulation_o,
  output logic                         fading_o,
  output logic                         overlay_mode_o
);

  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned TB = TIME_BITS;
  localparam int unsigned NW = CB + TB;
  localparam int unsigned CW = (CB > PortChBits) ? CB : PortChBits;
  localparam int unsigned DW = (TB > PortTimeBits) ? TB : PortTimeBits;
  localparam logic [CB-1:0] ChMax   = {CB{1'b1}};
  localparam logic [TB-1:0] TimeMax = {TB{1'b1}};

  typedef logic [CB-1:0] chan_t;

  // Fade state.
  chan_t         start_q [NumCh];
  chan_t         start_d [NumCh];
  chan_t         goal_q [NumCh];
  chan_t         goal_d [NumCh];
  chan_t         present_q [NumCh];
  chan_t         present_d [NumCh];
  chan_t         overlay_q [NumCh];
  chan_t         overlay_d [NumCh];
  logic [TB-1:0] time_q, time_d;
  logic [TB-1:0] len_q, len_d;
  logic [TB-1:0] elapsed_q, elapsed_d;
  chan_t         bright_q, bright_d;
  logic          fade_q, fade_d;
  logic          ovl_q, ovl_d;

  // Divider lanes, one per channel.
  logic [TB-1:0] rem_q [NumCh];
  chan_t         quo_q [NumCh];
  logic [TB:0]   rem_sh [NumCh];
  logic [TB:0]   rem_sub [NumCh];
  logic          rem_ge [NumCh];

  // Result register.
  chan_t         res_present_q [NumCh];
  chan_t         res_overlay_q [NumCh];
  chan_t         res_bright_q;
  logic          res_fade_q;
  logic          res_ovl_q;

  // Input conversion.
  logic [PortChBits-1:0] tgt_port [NumCh];
  chan_t                 tgt_ch [NumCh];
  logic [CW-1:0]         tgt_wide [NumCh];
  logic [DW-1:0]         dur_wide;
  logic [DW-1:0]         el_wide;
  logic [TB-1:0]         dur_sat;
  logic [TB-1:0]         el_sat;
  logic [TB:0]           time_sum;
  logic                  expired;

  // Interpolation results.
  chan_t                 lane_diff [NumCh];
  logic                  lane_up [NumCh];
  chan_t                 lane_step [NumCh];
  chan_t                 lane_res [NumCh];

  // Shared multiplier operands.
  chan_t                 mul_diff;
  logic [NW-1:0]         mul_num;

  assign tgt_port[0] = target_red_i;
  assign tgt_port[1] = target_green_i;
  assign tgt_port[2] = target_blue_i;
  assign tgt_port[3] = target_alpha_i;

  // Bring port values into the internal widths, saturating the times.
  always_comb begin
    for (int k = 0; k < NumCh; k++) begin
      tgt_wide[k] = CW'(tgt_port[k]);
      tgt_ch[k]   = tgt_wide[k][CB-1:0];
    end
    dur_wide = DW'(duration_ms_i);
    el_wide  = DW'(elapsed_ms_i);
    dur_sat  = (dur_wide > DW'(TimeMax)) ? TimeMax : dur_wide[TB-1:0];
    el_sat   = (el_wide > DW'(TimeMax)) ? TimeMax : el_wide[TB-1:0];
  end

  assign expired  = (time_q >= len_q);
  assign time_sum = {1'b0, time_q} + {1'b0, elapsed_q};
  assign sts_o.active  = fade_q;
  assign sts_o.expired = expired;

  // Numerator of one lane: |goal - start| * time + length / 2.
  always_comb begin
    if (goal_q[cmd_i.lane_sel] >= start_q[cmd_i.lane_sel]) begin
      mul_diff = goal_q[cmd_i.lane_sel] - start_q[cmd_i.lane_sel];
    end else begin
      mul_diff = start_q[cmd_i.lane_sel] - goal_q[cmd_i.lane_sel];
    end
    mul_num = NW'(mul_diff) * NW'(time_q) + NW'(len_q >> 1);
  end

  // One restoring division step per lane; the quotient shifts in at the bottom.
  always_comb begin
    for (int k = 0; k < NumCh; k++) begin
      rem_sh[k]  = {rem_q[k], quo_q[k][CB-1]};
      rem_ge[k]  = (rem_sh[k] >= {1'b0, len_q});
      rem_sub[k] = rem_sh[k] - {1'b0, len_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lane_mul) begin
      rem_q[cmd_i.lane_sel] <= mul_num[NW-1:CB];
      quo_q[cmd_i.lane_sel] <= mul_num[CB-1:0];
    end else if (cmd_i.div_step) begin
      for (int k = 0; k < NumCh; k++) begin
        rem_q[k] <= rem_ge[k] ? rem_sub[k][TB-1:0] : rem_sh[k][TB-1:0];
        quo_q[k] <= {quo_q[k][CB-2:0], rem_ge[k]};
      end
    end
  end

  // Clamp the rounded step to the distance and move away from the start.
  always_comb begin
    for (int k = 0; k < NumCh; k++) begin
      lane_up[k]   = (goal_q[k] >= start_q[k]);
      lane_diff[k] = lane_up[k] ? (goal_q[k] - start_q[k]) : (start_q[k] - goal_q[k]);
      lane_step[k] = (quo_q[k] > lane_diff[k]) ? lane_diff[k] : quo_q[k];
      lane_res[k]  = lane_up[k] ? (start_q[k] + lane_step[k]) : (start_q[k] - lane_step[k]);
    end
  end

  // Next fade state: a start loads, a tick sets elapsed, a commit updates.
  always_comb begin
    for (int k = 0; k < NumCh; k++) begin
      start_d[k]   = start_q[k];
      goal_d[k]    = goal_q[k];
      present_d[k] = present_q[k];
      overlay_d[k] = overlay_q[k];
    end
    time_d    = time_q;
    len_d     = len_q;
    elapsed_d = elapsed_q;
    bright_d  = bright_q;
    fade_d    = fade_q;
    ovl_d     = ovl_q;

    if (cmd_i.load) begin
      if (op_i == OpStart) begin
        for (int k = 0; k < NumCh; k++) begin
          start_d[k] = present_q[k];
          goal_d[k]  = tgt_ch[k];
        end
        time_d    = '0;
        len_d     = dur_sat;
        elapsed_d = '0;
        fade_d    = 1'b1;
        ovl_d     = !((present_q[0] == '0) && (present_q[1] == '0) &&
                      (present_q[2] == '0) && (tgt_ch[0] == '0) &&
                      (tgt_ch[1] == '0) && (tgt_ch[2] == '0));
        if (ovl_d) begin
          bright_d = ChMax;
        end
      end else begin
        elapsed_d = el_sat;
      end
    end else if (cmd_i.commit && fade_q) begin
      if (expired) begin
        // End of the fade: snap to the goal and settle the mode.
        for (int k = 0; k < NumCh; k++) begin
          present_d[k] = goal_q[k];
        end
        fade_d = 1'b0;
        if (ovl_q) begin
          if ((goal_q[AlphaIdx] == '0) ||
              ((goal_q[0] == '0) && (goal_q[1] == '0) && (goal_q[2] == '0))) begin
            ovl_d    = 1'b0;
            bright_d = ChMax - goal_q[AlphaIdx];
          end
        end else begin
          bright_d = ChMax - goal_q[AlphaIdx];
        end
      end else begin
        // Within the fade: a clear end keeps the RGB of the other end.
        present_d[AlphaIdx] = lane_res[AlphaIdx];
        for (int k = 0; k < NumRgb; k++) begin
          if (goal_q[AlphaIdx] == '0) begin
            present_d[k] = start_q[k];
          end else if (start_q[AlphaIdx] == '0) begin
            present_d[k] = goal_q[k];
          end else begin
            present_d[k] = lane_res[k];
          end
        end
        if (!ovl_q) begin
          bright_d = ChMax - lane_res[AlphaIdx];
        end else begin
          for (int k = 0; k < NumCh; k++) begin
            overlay_d[k] = present_d[k];
          end
        end
      end
      time_d = time_sum[TB] ? TimeMax : time_sum[TB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumCh; k++) begin
        start_q[k]   <= '0;
        goal_q[k]    <= '0;
        present_q[k] <= '0;
        overlay_q[k] <= '0;
      end
      time_q    <= '0;
      len_q     <= '0;
      elapsed_q <= '0;
      bright_q  <= ChMax;
      fade_q    <= 1'b0;
      ovl_q     <= 1'b0;
    end else begin
      for (int k = 0; k < NumCh; k++) begin
        start_q[k]   <= start_d[k];
        goal_q[k]    <= goal_d[k];
        present_q[k] <= present_d[k];
        overlay_q[k] <= overlay_d[k];
      end
      time_q    <= time_d;
      len_q     <= len_d;
      elapsed_q <= elapsed_d;
      bright_q  <= bright_d;
      fade_q    <= fade_d;
      ovl_q     <= ovl_d;
    end
  end

  // Result register, loaded with the state after the update step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      for (int k = 0; k < NumCh; k++) begin
        res_present_q[k] <= present_d[k];
        res_overlay_q[k] <= overlay_d[k];
      end
      res_bright_q <= bright_d;
      res_fade_q   <= fade_d;
      res_ovl_q    <= ovl_d;
    end
  end

  // Widen or trim channels to the port width.
  function automatic logic [PortChBits-1:0] to_port(input chan_t c);
    logic [CW-1:0] w;
    w = CW'(c);
    return w[PortChBits-1:0];
  endfunction

  assign color_red_o     = to_port(res_present_q[0]);
  assign color_green_o   = to_port(res_present_q[1]);
  assign color_blue_o    = to_port(res_present_q[2]);
  assign color_alpha_o   = to_port(res_present_q[3]);
  assign overlay_red_o   = to_port(res_overlay_q[0]);
  assign overlay_green_o = to_port(res_overlay_q[1]);
  assign overlay_blue_o  = to_port(res_overlay_q[2]);
  assign overlay_alpha_o = to_port(res_overlay_q[3]);
  assign modulation_o    = to_port(res_bright_q);
  assign fading_o        = res_fade_q;
  assign overlay_mode_o  = res_ovl_q;

endmodule

`default_nettype wire

FILE: rtl/core/timed_color_fade.sv
`default_nettype none

// Screen fade engine. Each input transfer is either a start (latch the present RGBA colour,
// take a target colour and a duration in ms) or a tick (add elapsed ms), and each one yields
// exactly one output transfer carrying the colour, the overlay colour, the modulation factor
// and the mode flags after the update. Channels move linearly from start to target with
// rounding; if one end is fully clear, RGB holds the other end's value. When no fade is
// running or the fade has just ended, an item skips the interpolation; while interpolating,
// one shared multiplier forms the numerator of each of the four channels in turn, then four
// restoring dividers produce one quotient bit per cycle. A new item is taken while the
// previous result still waits at the output.
module timed_color_fade import tcf_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = ChannelBitsDef,
  parameter int unsigned TIME_BITS    = TimeBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tcf_in_if.sink    in_if,
  tcf_out_if.source out_if
);

  tcf_cmd_t cmd;
  tcf_sts_t sts;

  // Sequencer for the handshakes and the divider steps.
  tcf_ctrl #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Fade state, interpolation lanes and result register.
  tcf_dp #(
    .CHANNEL_BITS(CHANNEL_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (in_if.op),
    .target_red_i   (in_if.target_red),
    .target_green_i (in_if.target_green),
    .target_blue_i  (in_if.target_blue),
    .target_alpha_i (in_if.target_alpha),
    .duration_ms_i  (in_if.duration_ms),
    .elapsed_ms_i   (in_if.elapsed_ms),
    .color_red_o    (out_if.color_red),
    .color_green_o  (out_if.color_green),
    .color_blue_o   (out_if.color_blue),
    .color_alpha_o  (out_if.color_alpha),
    .overlay_red_o  (out_if.overlay_red),
    .overlay_green_o(out_if.overlay_green),
    .overlay_blue_o (out_if.overlay_blue),
    .overlay_alpha_o(out_if.overlay_alpha),
    .modulation_o   (out_if.modulation),
    .fading_o       (out_if.fading),
    .overlay_mode_o (out_if.overlay_mode)
  );

endmodule

`default_nettype wire
